[hw/rtl/bmff_pkg.sv]
// Shared types, constants and helper function for the bitmap first-fit allocator.
package bmff_pkg;

  localparam int MAP_WORDS = 128;
  localparam int WORD_BITS = 32;
  localparam int CAPACITY  = MAP_WORDS * WORD_BITS;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int MEM_AW    = ADDR_W + 1;
  localparam int MEM_DEPTH = 2 * MAP_WORDS;
  localparam int LIMIT_W   = 13;
  localparam int IDX_W     = 12;
  localparam int OUT_W     = 32;
  localparam int IN_W      = 32;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_NOSPACE = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EVAL = 1'b1
  } state_e;

  typedef enum logic {
    CFG_INODE_LIMIT = 1'b0,
    CFG_ZONE_LIMIT  = 1'b1
  } cfg_index_e;

  typedef struct packed {
    req_type_e        req_type;
    logic             pool;
    logic [IDX_W-1:0] free_index;
    logic [6:0]       word_addr;
    logic [IN_W-1:0]  word_in;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] granted_index;
    logic [OUT_W-1:0] word_out;
  } rsp_t;

  typedef struct packed {
    logic                 we;
    logic [MEM_AW-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 re;
    logic [MEM_AW-1:0]    raddr;
  } mem_req_t;

  function automatic logic [BIT_W-1:0] first_one(logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

[hw/rtl/bitmap_first_fit_allocator.sv]
// Top level of the bitmap first-fit allocator for index node and zone pools.
// Free, word write and word read: the word is read into the RAM read register, evaluated,
// and the result goes to the output register once that is free. Allocate: the same, but
// the scan reads one map word per cycle from word 0 (up to 128 words) to a free bit or the limit.
// Take the next transaction once the result is in the output register.
// Reset clears limits, control state and all map valid bits, so both maps read as free.
module bitmap_first_fit_allocator
  import bmff_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  req_t               in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rsp_t               out_rsp_o
);

  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] rdata;

  bmff_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .mem_req_o   (mem_req),
    .rdata_i     (rdata)
  );

  bmff_map_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mem_req_i (mem_req),
    .rdata_o   (rdata)
  );

endmodule

[hw/rtl/bmff_map_ram.sv]
// Bitmap storage for both pools with per-word valid bits and registered read.
module bmff_map_ram
  import bmff_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mem_req_t             mem_req_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_q;
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem[mem_req_i.waddr] <= mem_req_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_req_i.we) begin
      vld_q[mem_req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_req_i.re) begin
      rdata_q <= vld_q[mem_req_i.raddr] ? mem[mem_req_i.raddr] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bmff_ctrl.sv]
// Request sequencer: limit registers, word scan, read-modify-write and result register.
module bmff_ctrl
  import bmff_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [LIMIT_W-1:0]   cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  req_t                 in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rsp_t                 out_rsp_o,
  output mem_req_t             mem_req_o,
  input  logic [WORD_BITS-1:0] rdata_i
);

  state_e               state_q, state_d;
  req_t                 req_q;
  logic                 ok_q, ok_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic [ADDR_W-1:0]    last_q, last_d;
  logic [BIT_W-1:0]     tail_q, tail_d;
  logic [LIMIT_W-1:0]   inode_limit_q, zone_limit_q;
  rsp_t                 rsp_q, rsp_d;
  logic                 out_valid_q, out_valid_d;

  logic                 accept;
  logic [LIMIT_W-1:0]   limit;
  logic [LIMIT_W-1:0]   limit_m1;
  logic                 limit_ok;
  logic [WORD_BITS-1:0] lim_mask;
  logic [WORD_BITS-1:0] cand;
  logic                 found;
  logic [BIT_W-1:0]     pos;
  logic                 is_last;
  logic                 scan_more;
  logic                 out_free;
  logic                 finish;
  logic [BIT_W-1:0]     fbit;

  assign accept   = in_valid_i && in_ready_o;
  assign limit    = in_req_i.pool ? zone_limit_q : inode_limit_q;
  assign limit_m1 = limit - LIMIT_W'(1);
  assign limit_ok = (limit != '0) && (limit <= LIMIT_W'(CAPACITY));

  assign lim_mask  = (is_last && (tail_q != '0)) ?
                     ((WORD_BITS'(1) << tail_q) - WORD_BITS'(1)) : '1;
  assign cand      = ~rdata_i & lim_mask;
  assign found     = |cand;
  assign pos       = first_one(cand);
  assign is_last   = (addr_q == last_q);
  assign scan_more = (req_q.req_type == REQ_ALLOC) && ok_q && !found && !is_last;
  assign out_free  = !out_valid_q || out_ready_i;
  assign finish    = (state_q == S_EVAL) && !scan_more && out_free;
  assign fbit      = req_q.free_index[BIT_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (finish) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    mem_req_o   = '0;
    ok_d        = ok_q;
    addr_d      = addr_q;
    last_d      = last_q;
    tail_d      = tail_q;
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (accept) begin
      mem_req_o.re = 1'b1;
      last_d       = limit_m1[IDX_W-1:BIT_W];
      tail_d       = limit[BIT_W-1:0];
      case (in_req_i.req_type)
        REQ_ALLOC: begin
          addr_d = '0;
          ok_d   = limit_ok;
        end
        REQ_FREE: begin
          addr_d = in_req_i.free_index[IDX_W-1:BIT_W];
          ok_d   = (in_req_i.free_index != '0) &&
                   ({1'b0, in_req_i.free_index} < limit) &&
                   (limit <= LIMIT_W'(CAPACITY));
        end
        default: begin
          addr_d = in_req_i.word_addr[ADDR_W-1:0];
          ok_d   = (int'(in_req_i.word_addr) < MAP_WORDS);
        end
      endcase
      mem_req_o.raddr = {in_req_i.pool, addr_d};
    end

    if ((state_q == S_EVAL) && scan_more) begin
      addr_d          = addr_q + ADDR_W'(1);
      mem_req_o.re    = 1'b1;
      mem_req_o.raddr = {req_q.pool, addr_d};
    end

    mem_req_o.waddr = {req_q.pool, addr_q};

    if (finish) begin
      out_valid_d         = 1'b1;
      rsp_d.status        = STAT_INVALID;
      rsp_d.granted_index = '0;
      rsp_d.word_out      = '0;
      case (req_q.req_type)
        REQ_ALLOC: begin
          if (ok_q) begin
            if (found) begin
              rsp_d.status        = STAT_OK;
              rsp_d.granted_index = {addr_q, pos};
              mem_req_o.we        = 1'b1;
              mem_req_o.wdata     = rdata_i | (WORD_BITS'(1) << pos);
            end else begin
              rsp_d.status = STAT_NOSPACE;
            end
          end
        end
        REQ_FREE: begin
          if (ok_q && rdata_i[fbit]) begin
            rsp_d.status    = STAT_OK;
            mem_req_o.we    = 1'b1;
            mem_req_o.wdata = rdata_i & ~(WORD_BITS'(1) << fbit);
          end
        end
        REQ_WRITE: begin
          if (ok_q) begin
            rsp_d.status    = STAT_OK;
            mem_req_o.we    = 1'b1;
            mem_req_o.wdata = req_q.word_in[WORD_BITS-1:0];
          end
        end
        default: begin
          if (ok_q) begin
            rsp_d.status   = STAT_OK;
            rsp_d.word_out = rdata_i[OUT_W-1:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      inode_limit_q <= '0;
      zone_limit_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_INODE_LIMIT: inode_limit_q <= cfg_wdata_i;
          CFG_ZONE_LIMIT:  zone_limit_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    ok_q   <= ok_d;
    addr_q <= addr_d;
    last_q <= last_d;
    tail_q <= tail_d;
    rsp_q  <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

[hw/rtl/bmff_checker.sv]
// Port-level checker for the allocator and its bind to the top level.
module bmff_checker
  import bmff_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_rsp_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed or dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction taken while one is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != STAT_OK) |->
    (out_rsp_o.granted_index == '0) && (out_rsp_o.word_out == '0))
    else $error("failed request carries nonzero payload");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.granted_index != '0) |-> (out_rsp_o.word_out == '0))
    else $error("grant and word read reported together");

endmodule

bind bitmap_first_fit_allocator bmff_checker u_bmff_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
